// ===== rtl/core/path_mtu_cache_defines.svh =====
// Assertion macros for the path MTU cache
`ifndef PATH_MTU_CACHE_DEFINES_SVH
`define PATH_MTU_CACHE_DEFINES_SVH
`ifndef ASSERT_OFF
`define PMC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PMC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PMC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/pmc_pkg.sv =====
// Types and constants shared by the path MTU cache modules
`default_nettype none
package pmc_pkg;

	localparam logic [1:0] MODE_QUERY  = 2'd0;
	localparam logic [1:0] MODE_RECORD = 2'd1;
	localparam logic [1:0] MODE_SWEEP  = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_STALE = 2'd1;
	localparam logic [1:0] ST_NEW   = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [1:0] CFG_ENABLE   = 2'd0;
	localparam logic [1:0] CFG_FIXED    = 2'd1;
	localparam logic [1:0] CFG_DEFAULT  = 2'd2;
	localparam logic [1:0] CFG_REDISC   = 2'd3;

	localparam logic [15:0] MTU_RESET    = 16'd1500;
	localparam logic [30:0] REDISC_RESET = 31'd600;
	localparam logic [6:0]  FREED_MAX    = 7'd127;

	typedef struct packed {
		logic [1:0]  mode;
		logic        addr_family;
		logic [63:0] addr_upper;
		logic [63:0] addr_lower;
		logic [15:0] new_mtu;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [15:0] mtu;
		logic [1:0]  status;
		logic        discover;
		logic [6:0]  freed_count;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic        family;
		logic [63:0] upper;
		logic [63:0] lower;
		logic [15:0] mtu;
		logic [31:0] stamp;
	} entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/pmc_cell.sv =====
// One table entry of the rotating cache ring
`default_nettype none
module pmc_cell
	import pmc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift,
	input  wire entry_t d,
	output entry_t      q
);

	logic        valid_q;
	logic        family_q;
	logic [63:0] upper_q;
	logic [63:0] lower_q;
	logic [15:0] mtu_q;
	logic [31:0] stamp_q;

	// take the neighbor's entry; only the valid bit is cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			family_q <= d.family;
			upper_q  <= d.upper;
			lower_q  <= d.lower;
			mtu_q    <= d.mtu;
			stamp_q  <= d.stamp;
		end
	end

	assign q = '{valid: valid_q, family: family_q, upper: upper_q, lower: lower_q,
		mtu: mtu_q, stamp: stamp_q};

endmodule
`default_nettype wire

// ===== rtl/core/path_mtu_cache.sv =====
// Path MTU cache: ring of entry cells rotated past one control head
//  channel | signals                         | handshake
//  request | start, busy, req                | taken when start & !busy
//  result  | done, res                       | one-cycle strobe, no stall
//  config  | cfg_we, cfg_idx, cfg_data       | write when cfg_we
// The ring turns once per pass, one entry per cycle. Query, record and sweep
// scan with one pass; an insert adds a second pass. A query with discovery
// off, or the unused mode, answers straight from idle without a pass. No
// clearing pass after reset: reset clears every valid bit at once. Results
// cannot be stalled.
`default_nettype none
module path_mtu_cache
	import pmc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire req_t        req,
	output logic             done,
	output res_t             res,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [30:0] cfg_data
);
`include "path_mtu_cache_defines.svh"

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FIN   = 2'd2;
	localparam logic [1:0] S_PLACE = 2'd3;

	logic        enable_q;
	logic [15:0] fixed_q, default_q;
	logic [30:0] redisc_q;

	logic [1:0]    state_q;
	req_t          req_q;
	logic [IW-1:0] cnt_q, free_idx_q;
	logic          hit_q, stale_q, free_q;
	logic [15:0]   hit_mtu_q;
	logic [6:0]    freed_q;
	logic          done_q;
	res_t          res_q;

	entry_t ring [TABLE_ENTRIES];
	entry_t head, tail, new_ent;
	logic   shift, match, aged, old, claim, fin;
	logic [31:0] age;
	res_t   fin_res;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			fixed_q   <= MTU_RESET;
			default_q <= MTU_RESET;
			redisc_q  <= REDISC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ENABLE:  enable_q  <= cfg_data[0];
				CFG_FIXED:   fixed_q   <= cfg_data[15:0];
				CFG_DEFAULT: default_q <= cfg_data[15:0];
				CFG_REDISC:  redisc_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// ring of cells
	assign head  = ring[0];
	assign shift = (state_q == S_SCAN) || (state_q == S_PLACE);
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		if (i == TABLE_ENTRIES - 1) begin : g_tail
			pmc_cell u_cell (.clk, .arst_n, .shift, .d(tail), .q(ring[i]));
		end else begin : g_mid
			pmc_cell u_cell (.clk, .arst_n, .shift, .d(ring[i+1]), .q(ring[i]));
		end
	end

	// compare the head entry
	assign match = head.valid && (head.family == req_q.addr_family) &&
		(head.upper == req_q.addr_upper) && (head.lower == req_q.addr_lower);
	assign age   = req_q.now - head.stamp;
	assign aged  = (age < {1'b0, redisc_q}) ? 1'b0 : 1'b1;
	assign old   = head.valid && (age >= {redisc_q, 1'b0});
	assign claim = (req_q.mode == MODE_QUERY) || (req_q.mode == MODE_RECORD);
	assign fin   = (state_q == S_FIN) && !(claim && !hit_q && free_q);

	always_comb begin
		new_ent.valid  = 1'b1;
		new_ent.family = req_q.addr_family;
		new_ent.upper  = req_q.addr_upper;
		new_ent.lower  = req_q.addr_lower;
		new_ent.mtu    = (req_q.mode == MODE_QUERY) ? default_q : req_q.new_mtu;
		new_ent.stamp  = req_q.now;
	end

	// modify the head on its way to the tail
	always_comb begin
		tail = head;
		if (state_q == S_SCAN) begin
			if (req_q.mode == MODE_RECORD && match) begin
				tail.mtu   = req_q.new_mtu;
				tail.stamp = req_q.now;
			end else if (req_q.mode == MODE_SWEEP && old) begin
				tail.valid = 1'b0;
			end
		end else if (state_q == S_PLACE && cnt_q == free_idx_q) begin
			tail = new_ent;
		end
	end

	// build the final word
	always_comb begin
		fin_res = '0;
		unique case (req_q.mode)
			MODE_QUERY: begin
				if (hit_q) begin
					fin_res.mtu      = hit_mtu_q;
					fin_res.status   = stale_q ? ST_STALE : ST_OK;
					fin_res.discover = stale_q;
				end else begin
					fin_res.mtu      = default_q;
					fin_res.status   = free_q ? ST_NEW : ST_FULL;
					fin_res.discover = 1'b1;
				end
			end
			MODE_RECORD: fin_res.status = hit_q ? ST_OK : (free_q ? ST_NEW : ST_FULL);
			MODE_SWEEP:  fin_res.freed_count = freed_q;
			default:     ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			freed_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						freed_q <= '0;
						if (req.mode == MODE_NONE ||
							(req.mode == MODE_QUERY && !enable_q)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (match) begin
						hit_q <= 1'b1;
					end
					if (!head.valid && !free_q) begin
						free_q <= 1'b1;
					end
					if (req_q.mode == MODE_SWEEP && old && freed_q != FREED_MAX) begin
						freed_q <= freed_q + 7'd1;
					end
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + IW'(1);
					if (cnt_q == LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + IW'(1);
					if (cnt_q == LAST) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
			if (req.mode == MODE_QUERY && !enable_q) begin
				res_q <= '{mtu: fixed_q, status: ST_OK, discover: 1'b0, freed_count: 7'd0};
			end else begin
				res_q <= '0;
			end
		end
		if (state_q == S_SCAN && match) begin
			stale_q   <= aged;
			hit_mtu_q <= aged ? default_q : head.mtu;
		end
		if (state_q == S_SCAN && !head.valid && !free_q) begin
			free_idx_q <= cnt_q;
		end
		if (fin || (state_q == S_PLACE && cnt_q == LAST)) begin
			res_q <= fin_res;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	`PMC_NEVER(a_done_idle, clk, arst_n, done && busy, "result word while busy")
	`PMC_ASSERT(a_none_fast, clk, arst_n, (start && !busy && req.mode == MODE_NONE) |=> done, "unused mode not answered at once")
	`PMC_ASSERT(a_rise_quiet, clk, arst_n, $rose(busy) |-> !done, "result word at item start")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the path MTU cache: directed and random commands, scoreboard check
`timescale 1ns / 100ps
`default_nettype none

class mtu_scoreboard;
	// configuration copy
	bit        enable;
	bit [15:0] fixed_mtu;
	bit [15:0] default_mtu;
	bit [30:0] redisc;
	// table copy
	bit        valid [64];
	bit        family [64];
	bit [63:0] upper [64];
	bit [63:0] lower [64];
	bit [15:0] mtu [64];
	bit [31:0] stamp [64];
	pmc_pkg::res_t expected_q [$];
	int errors;
	int checked;

	function void clear();
		enable = 1'b1;
		fixed_mtu = pmc_pkg::MTU_RESET;
		default_mtu = pmc_pkg::MTU_RESET;
		redisc = pmc_pkg::REDISC_RESET;
		foreach (valid[i]) valid[i] = 1'b0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [30:0] data);
		case (idx)
			pmc_pkg::CFG_ENABLE: enable = data[0];
			pmc_pkg::CFG_FIXED: fixed_mtu = data[15:0];
			pmc_pkg::CFG_DEFAULT: default_mtu = data[15:0];
			pmc_pkg::CFG_REDISC: redisc = data;
		endcase
	endfunction

	function int lookup(pmc_pkg::req_t r);
		for (int i = 0; i < 64; i++)
			if (valid[i] && family[i] == r.addr_family && upper[i] == r.addr_upper &&
					lower[i] == r.addr_lower)
				return i;
		return -1;
	endfunction

	function int claim(pmc_pkg::req_t r, bit [15:0] m);
		for (int i = 0; i < 64; i++)
			if (!valid[i]) begin
				valid[i] = 1'b1;
				family[i] = r.addr_family;
				upper[i] = r.addr_upper;
				lower[i] = r.addr_lower;
				mtu[i] = m;
				stamp[i] = r.now;
				return i;
			end
		return -1;
	endfunction

	// note an accepted command word and predict its answer
	function void note_command(pmc_pkg::req_t r);
		pmc_pkg::res_t e;
		int idx;
		bit [31:0] age;
		e = '0;
		case (r.mode)
			pmc_pkg::MODE_QUERY: begin
				if (!enable) begin
					e.mtu = fixed_mtu;
				end else begin
					idx = lookup(r);
					if (idx >= 0) begin
						age = r.now - stamp[idx];
						if (age < {1'b0, redisc}) begin
							e.mtu = mtu[idx];
						end else begin
							e.mtu = default_mtu;
							e.status = pmc_pkg::ST_STALE;
							e.discover = 1'b1;
						end
					end else begin
						idx = claim(r, default_mtu);
						e.status = (idx >= 0) ? pmc_pkg::ST_NEW : pmc_pkg::ST_FULL;
						e.mtu = default_mtu;
						e.discover = 1'b1;
					end
				end
			end
			pmc_pkg::MODE_RECORD: begin
				idx = lookup(r);
				if (idx >= 0) begin
					mtu[idx] = r.new_mtu;
					stamp[idx] = r.now;
				end else begin
					idx = claim(r, r.new_mtu);
					e.status = (idx >= 0) ? pmc_pkg::ST_NEW : pmc_pkg::ST_FULL;
				end
			end
			pmc_pkg::MODE_SWEEP: begin
				for (int i = 0; i < 64; i++) begin
					age = r.now - stamp[i];
					if (valid[i] && {1'b0, age} >= {redisc, 1'b0}) begin
						valid[i] = 1'b0;
						if (e.freed_count < pmc_pkg::FREED_MAX)
							e.freed_count++;
					end
				end
			end
			default: ;
		endcase
		expected_q.push_back(e);
	endfunction

	// compare one answer word with the oldest prediction
	function void check_answer(pmc_pkg::res_t a);
		pmc_pkg::res_t e;
		if (expected_q.size() == 0) begin
			$error("answer with nothing pending: %h", a);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		checked++;
		if (a.mtu !== e.mtu) begin
			$error("mtu expected %0d actual %0d", e.mtu, a.mtu);
			errors++;
		end
		if (a.status !== e.status) begin
			$error("status expected %0d actual %0d", e.status, a.status);
			errors++;
		end
		if (a.discover !== e.discover) begin
			$error("discover expected %0d actual %0d", e.discover, a.discover);
			errors++;
		end
		if (a.freed_count !== e.freed_count) begin
			$error("freed_count expected %0d actual %0d", e.freed_count, a.freed_count);
			errors++;
		end
	endfunction
endclass

module testbench;
	import pmc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t res;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [30:0] cfg_data = '0;

	mtu_scoreboard board;
	int idle_cycles;
	int n_commands;
	bit [63:0] pool_upper [16];
	bit [63:0] pool_lower [16];
	bit [31:0] clock_now;

	path_mtu_cache dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// check every answer word and watch for a stuck block
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_answer(res);
		if (arst_n && !((start && !busy) || done || cfg_we)) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout waiting for the block");
				$display("RESULT: ERROR");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	// hold start across back-to-back words; drop it only for a gap
	task automatic send(req_t r);
		int gap;
		gap = $urandom_range(0, 3);
		cfg_we <= 1'b0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		board.note_command(r);
		n_commands++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (2 * 64 + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [30:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	function automatic req_t make(logic [1:0] m, int slot, bit [31:0] t);
		req_t r;
		r.mode = m;
		r.addr_family = slot[0];
		r.addr_upper = pool_upper[slot];
		r.addr_lower = pool_lower[slot];
		r.new_mtu = 16'($urandom_range(68, 65535));
		r.now = t;
		return r;
	endfunction

	// random commands mostly over a small address pool so hits and staleness occur
	task automatic random_phase(int count, int max_step);
		req_t r;
		int pick;
		for (int k = 0; k < count; k++) begin
			clock_now += $urandom_range(0, max_step);
			pick = $urandom_range(0, 99);
			r = make(2'($urandom_range(0, 1)), $urandom_range(0, 15), clock_now);
			if (pick < 5) begin
				r.mode = MODE_SWEEP;
			end else if (pick < 7) begin
				r.mode = MODE_NONE;
			end else if (pick < 20) begin
				r.addr_upper = {$urandom, $urandom};
				r.addr_lower = {$urandom, $urandom};
				r.addr_family = 1'($urandom_range(0, 1));
			end
			send(r);
		end
	endtask

	initial begin
		req_t r;
		board = new();
		board.clear();
		foreach (pool_upper[i]) begin
			pool_upper[i] = (i % 3 == 0) ? 64'd0 : {$urandom, $urandom};
			pool_lower[i] = {$urandom, $urandom};
		end
		pool_upper[1] = '1;
		pool_lower[1] = '1;
		pool_lower[2] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: miss, fresh hit, record, stale hit, sweep, unused mode
		clock_now = 32'hFFFF_FF00;
		send(make(MODE_QUERY, 1, clock_now));
		send(make(MODE_QUERY, 1, clock_now + 1));
		r = make(MODE_RECORD, 1, clock_now + 2);
		r.new_mtu = 16'd68;
		send(r);
		r = make(MODE_RECORD, 2, clock_now + 3);
		r.new_mtu = 16'hFFFF;
		send(r);
		send(make(MODE_QUERY, 1, clock_now + 10));
		send(make(MODE_QUERY, 2, clock_now + 600 + 3));
		r = make(MODE_QUERY, 2, 0);
		r.addr_family = ~r.addr_family;
		send(r);
		send(make(MODE_SWEEP, 0, clock_now + 1000));
		send(make(MODE_SWEEP, 0, clock_now + 1300));
		send(make(MODE_NONE, 3, clock_now));
		// fill the table to see the full status on query and record
		for (int i = 0; i < 66; i++) begin
			r = make(i[0] ? MODE_RECORD : MODE_QUERY, 0, clock_now);
			r.addr_lower = 64'(i);
			r.addr_upper = {$urandom, $urandom};
			send(r);
		end
		drain();

		// discovery off, extreme fixed MTU
		write_reg(CFG_ENABLE, 31'd0);
		write_reg(CFG_FIXED, 31'd65535);
		send(make(MODE_QUERY, 4, clock_now));
		drain();
		write_reg(CFG_FIXED, 31'd68);
		random_phase(100, 50);
		drain();

		// zero rediscovery time: every hit stale, every sweep frees all
		write_reg(CFG_ENABLE, 31'd1);
		write_reg(CFG_DEFAULT, 31'd68);
		write_reg(CFG_REDISC, 31'd0);
		random_phase(200, 3);
		drain();

		// largest rediscovery time
		write_reg(CFG_DEFAULT, 31'd65535);
		write_reg(CFG_REDISC, 31'h7FFF_FFFF);
		random_phase(300, 32'h2000_0000);
		drain();

		// short rediscovery time with mixed ages
		write_reg(CFG_DEFAULT, 31'd1280);
		write_reg(CFG_REDISC, 31'd1);
		random_phase(300, 2);
		drain();

		write_reg(CFG_DEFAULT, 31'd9000);
		write_reg(CFG_REDISC, 31'd100);
		random_phase(800, 40);
		drain();

		$display("covered %0d commands, %0d answers checked, through six register settings",
			n_commands, board.checked);
		if (board.errors == 0 && board.expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

`default_nettype wire
